// File: hdl/stable_priority_queue_macros.svh
// ---------------------------------------------------------------------------
// stable_priority_queue_macros.svh
// Assertion macros shared by the priority queue RTL.
// ---------------------------------------------------------------------------
`ifndef STABLE_PRIORITY_QUEUE_MACROS_SVH
`define STABLE_PRIORITY_QUEUE_MACROS_SVH

// Property checked on every rising edge, quiet while reset is held.
`define SPQ_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Property checked on every rising edge, reset included.
`define SPQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: hdl/spq_pkg.sv
// ---------------------------------------------------------------------------
// spq_pkg
// Types and codes shared by the priority queue cells, channels and top level.
// ---------------------------------------------------------------------------
package spq_pkg;

    localparam int TAG_W  = 16;
    localparam int LVL_W  = 2;
    localparam int STAT_W = 3;
    localparam int WAIT_W = 8;

    // highest valid priority level
    localparam logic [LVL_W-1:0] TOP_LEVEL = 2'd3;
    localparam logic [LVL_W-1:0] NO_LEVEL  = 2'd0;

    // result status codes
    localparam logic [STAT_W-1:0] ST_ADDED     = 3'd0;
    localparam logic [STAT_W-1:0] ST_FULL      = 3'd1;
    localparam logic [STAT_W-1:0] ST_BAD_LEVEL = 3'd2;
    localparam logic [STAT_W-1:0] ST_SERVED    = 3'd3;
    localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd4;

    // request kinds
    localparam logic KIND_ADD   = 1'b0;
    localparam logic KIND_SERVE = 1'b1;

    // contents of one cell as seen by its upstream neighbor
    typedef struct packed {
        logic             valid;
        logic [TAG_W-1:0] tag;
        logic [LVL_W-1:0] level;
    } t_slot;

    // scan token travelling down the chain
    typedef struct packed {
        logic             tok;     // token present at this link
        logic             found;   // winner already removed upstream
        logic [LVL_W-1:0] maxlvl;  // running max (scan) / target level (select)
        logic [TAG_W-1:0] tag;     // tag of the removed entry
        logic [LVL_W-1:0] level;   // level of the removed entry
    } t_link;

    // broadcast control from the top level to every cell
    typedef struct packed {
        logic             add_en;
        logic [TAG_W-1:0] add_tag;
        logic [LVL_W-1:0] add_level;
        logic             sel_phase;
    } t_ctrl;

endpackage

// File: hdl/spq_if.sv
// ---------------------------------------------------------------------------
// spq_req_if / spq_rsp_if
// Valid/ready channels for requests into and results out of the queue.
// ---------------------------------------------------------------------------
interface spq_req_if;
    logic                      valid;
    logic                      ready;
    logic                      kind;
    logic [spq_pkg::TAG_W-1:0] entry_tag;
    logic [spq_pkg::LVL_W-1:0] level;

    modport source (output valid, kind, entry_tag, level, input ready);
    modport sink   (input valid, kind, entry_tag, level, output ready);
endinterface

interface spq_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [spq_pkg::STAT_W-1:0] status;
    logic [spq_pkg::TAG_W-1:0]  served_tag;
    logic [spq_pkg::LVL_W-1:0]  served_level;
    logic [spq_pkg::WAIT_W-1:0] waiting;

    modport source (output valid, status, served_tag, served_level, waiting, input ready);
    modport sink   (input valid, status, served_tag, served_level, waiting, output ready);
endinterface

// File: hdl/spq_cell.sv
// ---------------------------------------------------------------------------
// spq_cell
// One queue slot: holds an entry, passes the scan token to the next cell and
// pulls its neighbor's entry up when the winner sits at or above it.
// ---------------------------------------------------------------------------
module spq_cell #(
    parameter int TW = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  spq_pkg::t_ctrl i_ctrl,
    input  logic           i_prev_valid,
    input  spq_pkg::t_link i_link,
    input  spq_pkg::t_slot i_next,
    output spq_pkg::t_link o_link,
    output spq_pkg::t_slot o_slot
);

    logic                        r_valid;
    logic [TW-1:0]               r_tag;
    logic [spq_pkg::LVL_W-1:0]   r_level;
    spq_pkg::t_link              r_link;
    spq_pkg::t_link              n_link;
    logic [spq_pkg::LVL_W-1:0]   w_own;
    logic                        w_hit;
    logic                        w_shift;
    logic                        w_append;

    assign w_own    = r_valid ? r_level : spq_pkg::NO_LEVEL;
    assign w_hit    = i_link.tok && i_ctrl.sel_phase && !i_link.found
                      && r_valid && (r_level == i_link.maxlvl);
    assign w_shift  = i_link.tok && i_ctrl.sel_phase && (i_link.found || w_hit);
    assign w_append = i_ctrl.add_en && !r_valid && i_prev_valid;

    // token update: running max during scan, winner capture during select
    always_comb begin
        n_link = i_link;
        if (i_link.tok && !i_ctrl.sel_phase) begin
            if (w_own > i_link.maxlvl) begin
                n_link.maxlvl = w_own;
            end
        end
        if (w_hit) begin
            n_link.found = 1'b1;
            n_link.tag   = spq_pkg::TAG_W'(r_tag);
            n_link.level = r_level;
        end
    end

    // token register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link <= '0;
        end else begin
            r_link <= n_link;
        end
    end

    // slot occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_shift) begin
            r_valid <= i_next.valid;
        end else if (w_append) begin
            r_valid <= 1'b1;
        end
    end

    // slot payload
    always_ff @(posedge i_clk) begin
        if (w_shift) begin
            r_tag   <= i_next.tag[TW-1:0];
            r_level <= i_next.level;
        end else if (w_append) begin
            r_tag   <= i_ctrl.add_tag[TW-1:0];
            r_level <= i_ctrl.add_level;
        end
    end

    assign o_link       = r_link;
    assign o_slot.valid = r_valid;
    assign o_slot.tag   = spq_pkg::TAG_W'(r_tag);
    assign o_slot.level = r_level;

endmodule

// File: hdl/stable_priority_queue.sv
// Timing: add, rejected add and serve of an empty queue pass from the request
//   transfer through the pending result register into the output register; a
//   serve first sends the token down the cells twice (max scan, then select and
//   shift) before its result goes into the output register.
// Throughput: one request at a time; next request is taken once the result is
//   in the output register, which may still wait for the sink.
// Reset: i_rst_n synchronous, active low; empties the queue, no clearing pass.
// ---------------------------------------------------------------------------
// stable_priority_queue
// Three-level stable priority queue built as a chain of cells.
// ---------------------------------------------------------------------------
`include "stable_priority_queue_macros.svh"

module stable_priority_queue #(
    parameter int CAPACITY = 128,
    parameter int TAG_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    spq_req_if.sink   i_req,
    spq_rsp_if.source o_rsp
);

    localparam int TW = (TAG_BITS < spq_pkg::TAG_W) ? TAG_BITS : spq_pkg::TAG_W;
    localparam int CW = $clog2(CAPACITY + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MAX  = 2'd1;
    localparam logic [1:0] S_SEL  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]                  r_state, n_state;
    logic [CW-1:0]               r_count, n_count;
    spq_pkg::t_link              r_head, n_head;
    logic [spq_pkg::STAT_W-1:0]  r_pend_status, n_pend_status;
    logic [spq_pkg::TAG_W-1:0]   r_pend_tag, n_pend_tag;
    logic [spq_pkg::LVL_W-1:0]   r_pend_level, n_pend_level;
    logic                        r_o_valid;
    logic [spq_pkg::STAT_W-1:0]  r_o_status;
    logic [spq_pkg::TAG_W-1:0]   r_o_tag;
    logic [spq_pkg::LVL_W-1:0]   r_o_level;
    logic [spq_pkg::WAIT_W-1:0]  r_o_waiting;
    spq_pkg::t_ctrl              w_ctrl;
    logic                        w_accept;
    logic                        w_load;
    logic                        w_full;

    spq_pkg::t_link w_link [CAPACITY+1];
    spq_pkg::t_slot w_slot [CAPACITY+1];

    assign w_accept = i_req.valid && i_req.ready;
    assign w_full   = (r_count == CW'(CAPACITY));
    assign w_load   = (r_state == S_DONE) && (!r_o_valid || o_rsp.ready);

    // broadcast to the cells
    assign w_ctrl.add_en    = w_accept && (i_req.kind == spq_pkg::KIND_ADD)
                              && (i_req.level != spq_pkg::NO_LEVEL) && !w_full;
    assign w_ctrl.add_tag   = i_req.entry_tag;
    assign w_ctrl.add_level = i_req.level;
    assign w_ctrl.sel_phase = (r_state == S_SEL);

    // cell chain
    assign w_link[0]        = r_head;
    assign w_slot[CAPACITY] = '0;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic w_prev_valid;
        if (g == 0) begin : g_first
            assign w_prev_valid = 1'b1;
        end else begin : g_rest
            assign w_prev_valid = w_slot[g-1].valid;
        end
        spq_cell #(
            .TW(TW)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (w_ctrl),
            .i_prev_valid (w_prev_valid),
            .i_link       (w_link[g]),
            .i_next       (w_slot[g+1]),
            .o_link       (w_link[g+1]),
            .o_slot       (w_slot[g])
        );
    end

    // sequencer
    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_head        = r_head;
        n_head.tok    = 1'b0;
        n_pend_status = r_pend_status;
        n_pend_tag    = r_pend_tag;
        n_pend_level  = r_pend_level;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_pend_tag   = '0;
                    n_pend_level = spq_pkg::NO_LEVEL;
                    n_state      = S_DONE;
                    if (i_req.kind == spq_pkg::KIND_ADD) begin
                        priority if (i_req.level == spq_pkg::NO_LEVEL) begin
                            n_pend_status = spq_pkg::ST_BAD_LEVEL;
                        end else if (w_full) begin
                            n_pend_status = spq_pkg::ST_FULL;
                        end else begin
                            n_pend_status = spq_pkg::ST_ADDED;
                            n_count       = r_count + CW'(1);
                        end
                    end else if (r_count == '0) begin
                        n_pend_status = spq_pkg::ST_EMPTY;
                    end else begin
                        n_head  = '0;
                        n_head.tok = 1'b1;
                        n_state = S_MAX;
                    end
                end
            end
            S_MAX: begin
                if (w_link[CAPACITY].tok) begin
                    n_head        = '0;
                    n_head.tok    = 1'b1;
                    n_head.maxlvl = w_link[CAPACITY].maxlvl;
                    n_state       = S_SEL;
                end
            end
            S_SEL: begin
                if (w_link[CAPACITY].tok) begin
                    n_pend_status = spq_pkg::ST_SERVED;
                    n_pend_tag    = w_link[CAPACITY].tag;
                    n_pend_level  = w_link[CAPACITY].level;
                    n_count       = r_count - CW'(1);
                    n_state       = S_DONE;
                end
            end
            S_DONE: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_head  <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_head  <= n_head;
        end
    end

    // pending result
    always_ff @(posedge i_clk) begin
        r_pend_status <= n_pend_status;
        r_pend_tag    <= n_pend_tag;
        r_pend_level  <= n_pend_level;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_load) begin
            r_o_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_o_status  <= r_pend_status;
            r_o_tag     <= r_pend_tag;
            r_o_level   <= r_pend_level;
            r_o_waiting <= spq_pkg::WAIT_W'(r_count);
        end
    end

    assign i_req.ready        = (r_state == S_IDLE);
    assign o_rsp.valid        = r_o_valid;
    assign o_rsp.status       = r_o_status;
    assign o_rsp.served_tag   = r_o_tag;
    assign o_rsp.served_level = r_o_level;
    assign o_rsp.waiting      = r_o_waiting;

    // checks
    `SPQ_ASSERT_ALWAYS(a_rst_clear, i_clk,
        !i_rst_n |=> (r_count == '0 && !r_o_valid),
        "queue not empty after reset")
    `SPQ_ASSERT_RST(a_count_bound, i_clk, i_rst_n,
        r_count <= CW'(CAPACITY),
        "entry count above capacity")
    `SPQ_ASSERT_RST(a_tok_phase, i_clk, i_rst_n,
        w_link[CAPACITY].tok |-> (r_state == S_MAX || r_state == S_SEL),
        "token left chain outside a scan")
    `SPQ_ASSERT_RST(a_sel_found, i_clk, i_rst_n,
        (r_state == S_SEL && w_link[CAPACITY].tok) |-> w_link[CAPACITY].found,
        "select pass found no entry")

endmodule
